/* design/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared sizes, codes, state type and result record of the first-fit run
// allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int POOL_ENTRIES = 4096;
    localparam int SLOT_COUNT   = 64;
    localparam int GROUP_SIZE   = 64;

    localparam int IDX_W  = 12;
    localparam int SLOT_W = 6;
    localparam int LEN_W  = 13;
    localparam int GRP_W  = 7;
    localparam int BND_W  = 2 * IDX_W;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_SCAN,
        ST_MARK,
        ST_RD_BND,
        ST_GET_BND,
        ST_FREE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] owner_slot;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
        logic [GRP_W-1:0]  group_count;
    } t_rsp;

endpackage

/* design/ffra_req_if.sv */
// ----------------------------------------------------------------------------
// ffra_req_if
// Request channel: valid, ready and one allocate or release request.
// ----------------------------------------------------------------------------
interface ffra_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ffra_pkg::LEN_W-1:0]  run_length;
    logic [ffra_pkg::SLOT_W-1:0] release_slot;

    modport source (output valid, output req_type, output run_length,
                    output release_slot, input ready);
    modport sink   (input valid, input req_type, input run_length,
                    input release_slot, output ready);
endinterface

/* design/ffra_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffra_rsp_if
// Result channel: valid, ready and the answer to one request.
// ----------------------------------------------------------------------------
interface ffra_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [ffra_pkg::SLOT_W-1:0] owner_slot;
    logic [ffra_pkg::IDX_W-1:0]  first_index;
    logic [ffra_pkg::IDX_W-1:0]  last_index;
    logic [ffra_pkg::GRP_W-1:0]  group_count;

    modport source (output valid, output ok, output owner_slot, output first_index,
                    output last_index, output group_count, input ready);
    modport sink   (input valid, input ok, input owner_slot, input first_index,
                    input last_index, input group_count, output ready);
endinterface

/* design/ffra_ram.sv */
// ----------------------------------------------------------------------------
// ffra_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ffra_ctrl.sv */
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer of the allocator: clears the free map after reset, searches the
// owner slots, scans the free map, marks or frees runs and holds the result.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffra_req_if.sink                    i_req,
    ffra_rsp_if.source                  o_rsp,
    output logic                        o_map_we,
    output logic [ffra_pkg::IDX_W-1:0]  o_map_waddr,
    output logic                        o_map_wdata,
    output logic                        o_map_re,
    output logic [ffra_pkg::IDX_W-1:0]  o_map_raddr,
    input  logic                        i_map_rdata,
    output logic                        o_bnd_we,
    output logic [ffra_pkg::SLOT_W-1:0] o_bnd_addr,
    output logic [ffra_pkg::BND_W-1:0]  o_bnd_wdata,
    output logic                        o_bnd_re,
    input  logic [ffra_pkg::BND_W-1:0]  i_bnd_rdata
);
    import ffra_pkg::*;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [LEN_W-1:0]    r_iss, n_iss;
    logic                r_pv, n_pv;
    logic [IDX_W-1:0]    r_pidx, n_pidx;
    logic [LEN_W-1:0]    r_run, n_run;
    logic [IDX_W-1:0]    r_first, n_first;
    logic [IDX_W-1:0]    r_last, n_last;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic                r_ok, n_ok;
    logic [SLOT_COUNT-1:0] r_busy, n_busy;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    logic                req_xfer;
    logic                out_free;
    logic [LEN_W-1:0]    run_next;
    logic                hit;
    logic [LEN_W-1:0]    first_calc;
    logic [LEN_W-1:0]    run_size;
    logic [LEN_W-1:0]    grp_sum;
    logic [GRP_W-1:0]    grp;

    assign req_xfer   = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign run_next   = i_map_rdata ? '0 : r_run + LEN_W'(1);
    assign hit        = r_pv && (run_next >= r_len);
    assign first_calc = {1'b0, r_pidx} + LEN_W'(1) - r_len;
    assign run_size   = {1'b0, r_last} - {1'b0, r_first} + LEN_W'(1);
    assign grp_sum    = run_size + LEN_W'(GROUP_SIZE - 1);
    assign grp        = GRP_W'(grp_sum / GROUP_SIZE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_ptr == IDX_W'(POOL_ENTRIES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_xfer) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_state = (i_req.run_length == '0) ? ST_DONE : ST_SLOT;
                    end else begin
                        n_state = r_busy[i_req.release_slot] ? ST_RD_BND : ST_DONE;
                    end
                end
            end
            ST_SLOT: begin
                if (!r_busy[r_slot]) n_state = ST_SCAN;
                else if (r_slot == SLOT_W'(SLOT_COUNT - 1)) n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (hit) n_state = ST_MARK;
                else if (r_pv && r_pidx == IDX_W'(POOL_ENTRIES - 1)) n_state = ST_DONE;
            end
            ST_MARK: begin
                if (r_ptr == r_last) n_state = ST_DONE;
            end
            ST_RD_BND:  n_state = ST_GET_BND;
            ST_GET_BND: n_state = ST_FREE;
            ST_FREE: begin
                if (r_ptr == r_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_len       = r_len;
        n_slot      = r_slot;
        n_iss       = r_iss;
        n_pv        = r_pv;
        n_pidx      = r_pidx;
        n_run       = r_run;
        n_first     = r_first;
        n_last      = r_last;
        n_ptr       = r_ptr;
        n_ok        = r_ok;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        i_req.ready = 1'b0;
        o_map_we    = 1'b0;
        o_map_waddr = r_ptr;
        o_map_wdata = 1'b0;
        o_map_re    = 1'b0;
        o_map_raddr = r_iss[IDX_W-1:0];
        o_bnd_we    = 1'b0;
        o_bnd_addr  = r_slot;
        o_bnd_wdata = {r_first, r_last};
        o_bnd_re    = 1'b0;

        if (r_out_valid && o_rsp.ready) n_out_valid = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                o_map_we = 1'b1;
                n_ptr    = r_ptr + IDX_W'(1);
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (req_xfer) begin
                    n_len  = i_req.run_length;
                    n_slot = (i_req.req_type == REQ_ALLOC) ? '0 : i_req.release_slot;
                    n_iss  = '0;
                    n_pv   = 1'b0;
                    n_run  = '0;
                    n_ok   = 1'b0;
                end
            end
            ST_SLOT: begin
                if (r_busy[r_slot] && r_slot != SLOT_W'(SLOT_COUNT - 1)) begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_SCAN: begin
                if (r_iss < LEN_W'(POOL_ENTRIES)) begin
                    o_map_re = 1'b1;
                    n_iss    = r_iss + LEN_W'(1);
                    n_pv     = 1'b1;
                    n_pidx   = r_iss[IDX_W-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) n_run = run_next;
                if (hit) begin
                    n_first = first_calc[IDX_W-1:0];
                    n_ptr   = first_calc[IDX_W-1:0];
                    n_last  = r_pidx;
                end
            end
            ST_MARK: begin
                o_map_we    = 1'b1;
                o_map_wdata = 1'b1;
                n_ptr       = r_ptr + IDX_W'(1);
                if (r_ptr == r_last) begin
                    o_bnd_we       = 1'b1;
                    n_busy[r_slot] = 1'b1;
                    n_ok           = 1'b1;
                end
            end
            ST_RD_BND: begin
                o_bnd_re = 1'b1;
            end
            ST_GET_BND: begin
                n_first        = i_bnd_rdata[BND_W-1:IDX_W];
                n_last         = i_bnd_rdata[IDX_W-1:0];
                n_ptr          = i_bnd_rdata[BND_W-1:IDX_W];
                n_busy[r_slot] = 1'b0;
                n_ok           = 1'b1;
            end
            ST_FREE: begin
                o_map_we = 1'b1;
                n_ptr    = r_ptr + IDX_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_ok) begin
                        n_out.ok          = 1'b1;
                        n_out.owner_slot  = r_slot;
                        n_out.first_index = r_first;
                        n_out.last_index  = r_last;
                        n_out.group_count = grp;
                    end else begin
                        n_out = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_ok        <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_slot  <= n_slot;
        r_iss   <= n_iss;
        r_pidx  <= n_pidx;
        r_run   <= n_run;
        r_first <= n_first;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.owner_slot  = r_out.owner_slot;
    assign o_rsp.first_index = r_out.first_index;
    assign o_rsp.last_index  = r_out.last_index;
    assign o_rsp.group_count = r_out.group_count;

endmodule

/* design/first_fit_run_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_run_allocator
// First-fit allocator of contiguous runs from a pool of 4096 entries for up
// to 64 owner slots.
//
// Requests arrive on i_req as valid/ready transfers; each request gives one
// result transfer on o_rsp. An allocate takes the lowest free slot and the
// first run of free entries of the requested length; a release frees the
// whole run of a busy slot. Rejected requests answer with ok low and all
// other fields zero.
// An allocate searches the owner slots, scans the free map entry by entry, marks
// the entries of the run and posts the result. A release reads the bounds of
// the slot, frees its entries and posts the result. The free map RAM is read
// or written one entry a cycle.
// Requests are handled one at a time; i_req.ready is high only between them.
// After reset the free map is cleared to all free, one entry a cycle,
// with i_req.ready low. A finished result waits in the output register
// while o_rsp.ready is low; the next request is still taken, and its result
// is held back until the register is free.
// ----------------------------------------------------------------------------
module first_fit_run_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffra_req_if.sink   i_req,
    ffra_rsp_if.source o_rsp
);
    import ffra_pkg::*;

    logic              map_we;
    logic [IDX_W-1:0]  map_waddr;
    logic              map_wdata;
    logic              map_re;
    logic [IDX_W-1:0]  map_raddr;
    logic              map_rdata;
    logic              bnd_we;
    logic [SLOT_W-1:0] bnd_addr;
    logic [BND_W-1:0]  bnd_wdata;
    logic              bnd_re;
    logic [BND_W-1:0]  bnd_rdata;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_map_we    (map_we),
        .o_map_waddr (map_waddr),
        .o_map_wdata (map_wdata),
        .o_map_re    (map_re),
        .o_map_raddr (map_raddr),
        .i_map_rdata (map_rdata),
        .o_bnd_we    (bnd_we),
        .o_bnd_addr  (bnd_addr),
        .o_bnd_wdata (bnd_wdata),
        .o_bnd_re    (bnd_re),
        .i_bnd_rdata (bnd_rdata)
    );

    ffra_ram #(
        .WIDTH (1),
        .DEPTH (POOL_ENTRIES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    ffra_ram #(
        .WIDTH (BND_W),
        .DEPTH (SLOT_COUNT)
    ) u_bnd_ram (
        .i_clk   (i_clk),
        .i_we    (bnd_we),
        .i_waddr (bnd_addr),
        .i_wdata (bnd_wdata),
        .i_re    (bnd_re),
        .i_raddr (bnd_addr),
        .o_rdata (bnd_rdata)
    );

endmodule

/* tb/sv/tb_first_fit_run_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_run_allocator
// Self-checking testbench of the first-fit run allocator. A directed opening
// covers empty and full pools, zero and oversized lengths, unused slots and
// hole reuse. Random traffic then mixes allocates, releases and malformed
// requests, fills every owner slot and sends twenty releases. A scoreboard keeps its
// own free map and slot table and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_first_fit_run_allocator;
    import ffra_pkg::*;

    class run_alloc_scoreboard;
        bit               entry_used [POOL_ENTRIES];
        bit               slot_busy  [SLOT_COUNT];
        logic [IDX_W-1:0] slot_first [SLOT_COUNT];
        logic [IDX_W-1:0] slot_last  [SLOT_COUNT];
        t_rsp             pending_answers [$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        function logic [GRP_W-1:0] groups_of(int len);
            return GRP_W'((len + GROUP_SIZE - 1) / GROUP_SIZE);
        endfunction

        function int busy_count();
            int n;
            n = 0;
            foreach (slot_busy[s]) n += slot_busy[s];
            return n;
        endfunction

        function int pick_busy_slot();
            int busy [$];
            foreach (slot_busy[s]) if (slot_busy[s]) busy.push_back(s);
            if (busy.size() == 0) return -1;
            return busy[$urandom_range(0, busy.size() - 1)];
        endfunction

        function void note_request(logic kind, logic [LEN_W-1:0] run_length,
                                   logic [SLOT_W-1:0] rel_slot);
            t_rsp answer;
            int   len;
            int   run;
            int   slot;
            int   first;
            int   last;
            answer = '0;
            len    = int'(run_length);
            if (kind == REQ_ALLOC) begin
                slot = -1;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (!slot_busy[s]) begin
                        slot = s;
                        break;
                    end
                end
                if (len != 0 && slot >= 0) begin
                    run = 0;
                    for (int i = 0; i < POOL_ENTRIES; i++) begin
                        run = entry_used[i] ? 0 : run + 1;
                        if (run >= len) begin
                            first = i + 1 - len;
                            for (int k = first; k <= i; k++) entry_used[k] = 1'b1;
                            slot_busy[slot]  = 1'b1;
                            slot_first[slot] = IDX_W'(first);
                            slot_last[slot]  = IDX_W'(i);
                            answer = '{1'b1, SLOT_W'(slot), IDX_W'(first), IDX_W'(i),
                                       groups_of(len)};
                            break;
                        end
                    end
                end
            end else if (slot_busy[rel_slot]) begin
                first = int'(slot_first[rel_slot]);
                last  = int'(slot_last[rel_slot]);
                if (first > last) first = last;
                for (int k = first; k <= last; k++) entry_used[k] = 1'b0;
                slot_busy[rel_slot] = 1'b0;
                answer = '{1'b1, rel_slot, IDX_W'(first), IDX_W'(last),
                           groups_of(last - first + 1)};
            end
            pending_answers.push_back(answer);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
                errors++;
            end
        endfunction

        function void check_answer(t_rsp got);
            t_rsp want;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("owner_slot", want.owner_slot, got.owner_slot);
            compare_field("first_index", want.first_index, got.first_index);
            compare_field("last_index", want.last_index, got.last_index);
            compare_field("group_count", want.group_count, got.group_count);
        endfunction
    endclass

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 70000;
    localparam int DRAIN_CYCLES   = 50;

    logic i_clk;
    logic i_rst_n;
    bit   idling_on;
    bit   hold_request;
    int   idle_cycles;

    run_alloc_scoreboard sb;

    ffra_req_if req_bus ();
    ffra_rsp_if rsp_bus ();

    first_fit_run_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_request(input logic kind, input logic [LEN_W-1:0] len,
                                input logic [SLOT_W-1:0] slot);
        if (idling_on && $urandom_range(0, 2) == 0) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        req_bus.valid        = 1'b1;
        req_bus.req_type     = kind;
        req_bus.run_length   = len;
        req_bus.release_slot = slot;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        sb.note_request(kind, len, slot);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int roll;
        int slot;
        roll = $urandom_range(0, 99);
        slot = sb.pick_busy_slot();
        if (roll < 35 && slot >= 0) begin
            send_request(REQ_RELEASE, LEN_W'($urandom), SLOT_W'(slot));
        end else if (roll < 45) begin
            case ($urandom_range(0, 3))
                0: send_request(REQ_ALLOC, '0, SLOT_W'($urandom));
                1: send_request(REQ_ALLOC, LEN_W'($urandom_range(4097, 8191)),
                                SLOT_W'($urandom));
                2: send_request(REQ_RELEASE, LEN_W'($urandom), SLOT_W'($urandom));
                default: send_request(REQ_ALLOC, LEN_W'($urandom_range(2048, 4096)),
                                      SLOT_W'($urandom));
            endcase
        end else if ($urandom_range(0, 7) == 0) begin
            send_request(REQ_ALLOC, LEN_W'($urandom_range(65, 512)), SLOT_W'($urandom));
        end else begin
            send_request(REQ_ALLOC, LEN_W'($urandom_range(1, 64)), SLOT_W'($urandom));
        end
    endtask

    task automatic wait_for_answers();
        req_bus.valid = 1'b0;
        while (sb.pending_answers.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                rsp_bus.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (idling_on && $urandom_range(0, 3) == 0) begin
                rsp_bus.ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                rsp_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_answer('{rsp_bus.ok, rsp_bus.owner_slot, rsp_bus.first_index,
                              rsp_bus.last_index, rsp_bus.group_count});
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int tries;
        sb                   = new();
        idling_on            = 1'b1;
        hold_request         = 1'b0;
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_ALLOC;
        req_bus.run_length   = '0;
        req_bus.release_slot = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening on an empty pool.
        send_request(REQ_ALLOC, 13'd0, 6'd0);
        send_request(REQ_RELEASE, 13'd0, 6'd0);
        send_request(REQ_RELEASE, 13'h1fff, 6'd63);
        send_request(REQ_ALLOC, 13'd4096, 6'd63);
        send_request(REQ_ALLOC, 13'd1, 6'd0);
        send_request(REQ_RELEASE, 13'd0, 6'd0);
        send_request(REQ_ALLOC, 13'd4097, 6'd0);
        send_request(REQ_ALLOC, 13'h1fff, 6'h3f);
        send_request(REQ_ALLOC, 13'd1, 6'd0);
        send_request(REQ_ALLOC, 13'd64, 6'd0);
        send_request(REQ_ALLOC, 13'd65, 6'd0);
        send_request(REQ_RELEASE, 13'd0, 6'd1);
        send_request(REQ_RELEASE, 13'd0, 6'd1);
        send_request(REQ_ALLOC, 13'd30, 6'd0);
        send_request(REQ_ALLOC, 13'd40, 6'd0);
        send_request(REQ_ALLOC, 13'd4096, 6'd0);
        send_request(REQ_RELEASE, 13'd0, 6'd0);
        send_request(REQ_ALLOC, 13'd1, 6'd0);

        repeat (30) send_random_item();

        // Result side holds off while requests keep coming.
        hold_request = 1'b1;
        repeat (6) send_random_item();
        wait_for_answers();

        // Take every owner slot, then ask for more.
        tries = 0;
        while (sb.busy_count() < SLOT_COUNT && tries < 100) begin
            send_request(REQ_ALLOC, LEN_W'($urandom_range(1, 8)), SLOT_W'($urandom));
            tries++;
        end
        repeat (3) send_request(REQ_ALLOC, LEN_W'($urandom_range(1, 64)), SLOT_W'($urandom));
        repeat (20) send_request(REQ_RELEASE, LEN_W'($urandom), SLOT_W'(sb.pick_busy_slot()));
        wait_for_answers();

        idling_on = 1'b0;
        repeat (20) send_random_item();

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
